// ===== design/grwaf_pkg.sv =====
// Package: constants, types and state encoding for the gap-rejecting window average filter.
`timescale 1ns / 1ps
`default_nettype none
package grwaf_pkg;

  localparam int WINDOW_MAX  = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int IDX_W       = 4;
  localparam int LEN_W       = 5;
  localparam int DIFF_W      = SAMPLE_BITS + 1;
  localparam int SUM_W       = SAMPLE_BITS + IDX_W;
  localparam int BITCNT_W    = 5;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam logic [LEN_W-1:0]  LEN_RESET = LEN_W'(8);
  localparam logic [LEN_W-1:0]  LEN_MIN   = LEN_W'(3);
  localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(WINDOW_MAX);
  localparam logic              REG_WINDOW_LENGTH = 1'b0;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SORT,
    ST_GAP,
    ST_SEL,
    ST_SUM,
    ST_SGN,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== design/gap_rejecting_window_average_filter.sv =====
// Top level: sliding-window filter that averages one side of the largest sorted gap.
//
// Usage:
//   Input channel in_valid/in_ready/in_sample carries one signed sample per item.
//   Result channel out_valid/out_ready/out_filtered returns one signed average per item.
//   APB-style port sets window_length (byte address 0, bits 4:0); write only when idle.
//   Values below 3 act as 3, above 16 act as 16; reads return the written value.
// Timing:
//   One item is worked at a time: a shared subtract/compare unit sorts the window by
//   insertion and scans the sorted gaps, an adder sums the kept side and a one bit per
//   cycle divider forms the average. With L the window length, the lower side of the
//   largest gap is kept if it holds more than (L+1)/2 values (integer division), else
//   the upper side, so L/2 to L-1 values are kept. in_ready is high only in the idle
//   state, so a new item is taken only after the last result is written to the output
//   register; a stalled result delays that write.
// Reset:
//   rst_n low clears the history to zeros, sets window_length to 8, drops any result.
// Stall:
//   A finished result waits in the output register; a following item is still taken
//   and its result is held back until the register drains.
`timescale 1ns / 1ps
`default_nettype none
module gap_rejecting_window_average_filter (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire  signed [grwaf_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic signed [grwaf_pkg::SAMPLE_BITS-1:0] out_filtered,
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire         [grwaf_pkg::ADDR_W-1:0]  paddr,
  input  wire         [grwaf_pkg::DATA_W-1:0]  pwdata,
  output logic        [grwaf_pkg::DATA_W-1:0]  prdata,
  output logic                                 pready
);

  localparam int IW = grwaf_pkg::IDX_W;
  localparam int LW = grwaf_pkg::LEN_W;
  localparam int SB = grwaf_pkg::SAMPLE_BITS;
  localparam int DW = grwaf_pkg::DIFF_W;
  localparam int SW = grwaf_pkg::SUM_W;
  localparam int BW = grwaf_pkg::BITCNT_W;
  localparam int WM = grwaf_pkg::WINDOW_MAX;

  grwaf_pkg::state_t state_r, state_nxt;

  logic [LW-1:0]        cfg_len_r;
  logic [LW-1:0]        eff_len;
  logic [LW-1:0]        len_r, len_nxt;
  grwaf_pkg::sample_t   hist_r [WM];
  grwaf_pkg::sample_t   scr_r  [WM];
  logic [IW-1:0]        i_r, i_nxt;
  logic [IW-1:0]        j_r, j_nxt;
  logic [IW-1:0]        g_r, g_nxt;
  logic [IW-1:0]        best_r, best_nxt;
  logic signed [DW-1:0] best_gap_r, best_gap_nxt;
  grwaf_pkg::sample_t   prev_r, prev_nxt;
  logic [LW-1:0]        end_r, end_nxt;
  logic [LW-1:0]        cnt_r, cnt_nxt;
  logic signed [SW-1:0] acc_r, acc_nxt;
  logic [SW-1:0]        quo_r, quo_nxt;
  logic [IW-1:0]        rem_r, rem_nxt;
  logic [BW-1:0]        bit_r, bit_nxt;
  logic                 neg_r, neg_nxt;
  logic                 out_valid_r, out_valid_nxt;
  grwaf_pkg::sample_t   out_data_r, out_data_nxt;

  logic                 cfg_we;
  logic                 accept;
  grwaf_pkg::sample_t   key;
  logic [IW-1:0]        scr_raddr;
  grwaf_pkg::sample_t   rd;
  grwaf_pkg::sample_t   op_a, op_b;
  logic signed [DW-1:0] diff;
  logic                 scr_we;
  logic [IW-1:0]        scr_waddr;
  grwaf_pkg::sample_t   scr_wdata;
  logic [LW-1:0]        t1;
  logic [LW-1:0]        half;
  logic [LW:0]          trial;
  logic [SW-1:0]        mag;

  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite && (paddr[2] == grwaf_pkg::REG_WINDOW_LENGTH);
  assign prdata   = (paddr[2] == grwaf_pkg::REG_WINDOW_LENGTH) ?
                    {{(grwaf_pkg::DATA_W-LW){1'b0}}, cfg_len_r} : '0;
  assign in_ready = (state_r == grwaf_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_valid    = out_valid_r;
  assign out_filtered = out_data_r;

  always_comb begin
    priority if (cfg_len_r < grwaf_pkg::LEN_MIN) begin
      eff_len = grwaf_pkg::LEN_MIN;
    end else if (cfg_len_r > grwaf_pkg::LEN_MAX) begin
      eff_len = grwaf_pkg::LEN_MAX;
    end else begin
      eff_len = cfg_len_r;
    end
  end

  assign key       = hist_r[i_r];
  assign scr_raddr = (state_r == grwaf_pkg::ST_SORT) ? (j_r - IW'(1)) : g_r;
  assign rd        = scr_r[scr_raddr];
  assign op_a      = (state_r == grwaf_pkg::ST_SORT) ? key : rd;
  assign op_b      = (state_r == grwaf_pkg::ST_SORT) ? rd  : prev_r;
  assign diff      = DW'(op_a) - DW'(op_b);
  assign t1        = LW'({1'b0, best_r}) + LW'(1);
  assign half      = LW'((LW+1)'(len_r) + (LW+1)'(1) >> 1);
  assign trial     = {1'b0, rem_r, quo_r[SW-1]};
  assign mag       = acc_r[SW-1] ? SW'(-acc_r) : SW'(acc_r);

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    g_nxt         = g_r;
    best_nxt      = best_r;
    best_gap_nxt  = best_gap_r;
    prev_nxt      = prev_r;
    end_nxt       = end_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    bit_nxt       = bit_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    scr_we        = 1'b0;
    scr_waddr     = j_r;
    scr_wdata     = key;
    unique case (state_r)
      grwaf_pkg::ST_IDLE: begin
        if (accept) begin
          len_nxt      = eff_len;
          i_nxt        = '0;
          j_nxt        = '0;
          state_nxt    = grwaf_pkg::ST_SORT;
        end
      end
      grwaf_pkg::ST_SORT: begin
        scr_we = 1'b1;
        if ((j_r != '0) && diff[DW-1]) begin
          scr_wdata = rd;
          j_nxt     = j_r - IW'(1);
        end else begin
          scr_wdata = key;
          if ((LW'(i_r) + LW'(1)) == len_r) begin
            g_nxt        = '0;
            best_nxt     = '0;
            best_gap_nxt = '1;
            state_nxt    = grwaf_pkg::ST_GAP;
          end else begin
            i_nxt = i_r + IW'(1);
            j_nxt = i_r + IW'(1);
          end
        end
      end
      grwaf_pkg::ST_GAP: begin
        prev_nxt = rd;
        if ((g_r != '0) && (diff > best_gap_r)) begin
          best_gap_nxt = diff;
          best_nxt     = g_r - IW'(1);
        end
        if ((LW'(g_r) + LW'(1)) == len_r) begin
          state_nxt = grwaf_pkg::ST_SEL;
        end else begin
          g_nxt = g_r + IW'(1);
        end
      end
      grwaf_pkg::ST_SEL: begin
        if (t1 > half) begin
          g_nxt   = '0;
          end_nxt = t1;
          cnt_nxt = t1;
        end else begin
          g_nxt   = t1[IW-1:0];
          end_nxt = len_r;
          cnt_nxt = len_r - t1;
        end
        acc_nxt   = '0;
        state_nxt = grwaf_pkg::ST_SUM;
      end
      grwaf_pkg::ST_SUM: begin
        acc_nxt = acc_r + SW'(rd);
        if ((LW'(g_r) + LW'(1)) == end_r) begin
          state_nxt = grwaf_pkg::ST_SGN;
        end else begin
          g_nxt = g_r + IW'(1);
        end
      end
      grwaf_pkg::ST_SGN: begin
        neg_nxt   = acc_r[SW-1];
        quo_nxt   = mag;
        rem_nxt   = '0;
        bit_nxt   = '0;
        state_nxt = grwaf_pkg::ST_DIV;
      end
      grwaf_pkg::ST_DIV: begin
        if (trial >= (LW+1)'(cnt_r)) begin
          rem_nxt = IW'(trial - (LW+1)'(cnt_r));
          quo_nxt = {quo_r[SW-2:0], 1'b1};
        end else begin
          rem_nxt = trial[IW-1:0];
          quo_nxt = {quo_r[SW-2:0], 1'b0};
        end
        bit_nxt = bit_r + BW'(1);
        if (bit_r == BW'(SW-1)) begin
          state_nxt = grwaf_pkg::ST_DONE;
        end
      end
      grwaf_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = neg_r ? -quo_r[SB-1:0] : quo_r[SB-1:0];
          state_nxt     = grwaf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = grwaf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= grwaf_pkg::ST_IDLE;
      cfg_len_r   <= grwaf_pkg::LEN_RESET;
      out_valid_r <= 1'b0;
      for (int k = 0; k < WM; k++) begin
        hist_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_len_r <= pwdata[LW-1:0];
      end
      if (accept) begin
        hist_r[0] <= in_sample;
        for (int k = 1; k < WM; k++) begin
          hist_r[k] <= hist_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    len_r      <= len_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    g_r        <= g_nxt;
    best_r     <= best_nxt;
    best_gap_r <= best_gap_nxt;
    prev_r     <= prev_nxt;
    end_r      <= end_nxt;
    cnt_r      <= cnt_nxt;
    acc_r      <= acc_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    bit_r      <= bit_nxt;
    neg_r      <= neg_nxt;
    out_data_r <= out_data_nxt;
    if (scr_we) begin
      scr_r[scr_waddr] <= scr_wdata;
    end
  end

endmodule
`default_nettype wire
